>>> hw/rtl/mitm_pkg.sv
// Shared types and constants of the max intensity tile merge block.
package mitm_pkg;

   localparam int unsigned MAX_PIXELS_DEFAULT = 262144;
   localparam int unsigned FRAME_PIXELS_W     = 19;
   localparam int unsigned COUNT_W            = 19;
   localparam int unsigned CSR_INDEX_W        = 1;
   localparam int unsigned CSR_DATA_W         = FRAME_PIXELS_W;
   localparam int unsigned RSP_DEPTH          = 3;

   localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RESET = 19'd65536;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PIXELS  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ENABLE = 1'd1;

   localparam logic [7:0] ALPHA_OPAQUE_MIN = 8'd250;
   localparam logic [7:0] BLACK_LEVEL_MAX  = 8'd5;

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic [7:0] pixel_alpha;
      logic       first_image;
      logic       last_image;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       frame_end;
      logic       reject;
   } rsp_type;

endpackage

>>> hw/rtl/max_intensity_tile_merge.sv
// Max intensity tile merge: top level with frame store and merge pipeline.
//
// Pixels of equally sized RGBA frames enter on the req_ channel in raster
// order, one transfer per cycle unless stalled. Each position of the frame
// store keeps the pixel with the greatest (R+G+B)*A; first_image makes the
// stored entry count as zero. Pixels flagged last_image produce one rsp_
// transfer carrying the merged pixel; frame_end marks the last position and
// reject carries the black/transparent verdict when filter_enable is set.
// Throughput is one pixel per cycle unless stalled: the store is read at
// acceptance and written back in the following cycle, with a one-entry
// bypass for a pixel that hits the entry still being written. rsp_valid
// rises once a last_image pixel has passed the stage-one registers into the
// result queue. Results wait in a three-entry queue; req_stall rises when
// the queue plus the pixel in flight would fill it, so a stalled receiver
// holds off input once results and the in-flight pixel reach three. Reset
// clears position, counters and queue; the store content is undefined
// until written by a first_image pixel, so no clearing pass runs.
module max_intensity_tile_merge import mitm_pkg::*; #(
   parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

   logic [31:0]               store [MAX_PIXELS];
   logic [31:0]               rd_data_ff;

   logic [FRAME_PIXELS_W-1:0] frame_pixels_ff;
   logic                      filter_enable_ff;

   logic [AW-1:0]             pos_ff, pos_in;
   logic [COUNT_W-1:0]        black_ff, black_in;
   logic [COUNT_W-1:0]        trans_ff, trans_in;

   logic                      s1_valid_ff;
   req_type                   s1_req_ff;
   logic [AW-1:0]             s1_addr_ff;
   logic                      s1_end_ff;
   logic                      fwd_ff;
   logic [31:0]               fwd_data_ff;

   logic [FRAME_PIXELS_W-1:0] n_eff;
   logic [FRAME_PIXELS_W-1:0] n_last;
   logic                      at_end;
   logic                      accept;
   logic [1:0]                fifo_count;

   logic [31:0]               held;
   logic [31:0]               merged;
   logic [9:0]                sum_new, sum_old;
   logic [17:0]               w_new, w_old;
   logic [7:0]                m_red, m_green, m_blue, m_alpha;
   logic                      is_trans, is_black;
   logic [COUNT_W-1:0]        black_next, trans_next;
   logic [24:0]               black_x4, trans_x20, n_x1, n_x3;
   logic                      reject;
   logic                      push;
   rsp_type                   push_data;

   always_comb begin
      if (frame_pixels_ff == '0) begin
         n_eff = FRAME_PIXELS_W'(1);
      end else if (32'(frame_pixels_ff) > 32'(MAX_PIXELS)) begin
         n_eff = FRAME_PIXELS_W'(MAX_PIXELS);
      end else begin
         n_eff = frame_pixels_ff;
      end
   end

   assign n_last    = n_eff - FRAME_PIXELS_W'(1);
   assign at_end    = (32'(pos_ff) >= 32'(n_last));
   assign req_stall = (32'(fifo_count) + 32'(s1_valid_ff)) >= 32'(RSP_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign pos_in    = at_end ? '0 : pos_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff  <= FRAME_PIXELS_RESET;
         filter_enable_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_PIXELS:  frame_pixels_ff  <= csr_wdata;
            CSR_FILTER_ENABLE: filter_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         store[s1_addr_ff] <= merged;
      end
      if (accept) begin
         rd_data_ff <= store[pos_ff];
      end
   end

   always_comb begin
      if (s1_req_ff.first_image) begin
         held = '0;
      end else if (fwd_ff) begin
         held = fwd_data_ff;
      end else begin
         held = rd_data_ff;
      end
   end

   assign sum_new = 10'(s1_req_ff.pixel_red) + 10'(s1_req_ff.pixel_green)
                  + 10'(s1_req_ff.pixel_blue);
   assign sum_old = 10'(held[7:0]) + 10'(held[15:8]) + 10'(held[23:16]);
   assign w_new   = 18'(18'(sum_new) * 18'(s1_req_ff.pixel_alpha));
   assign w_old   = 18'(18'(sum_old) * 18'(held[31:24]));

   assign merged = (w_new > w_old) ?
                   {s1_req_ff.pixel_alpha, s1_req_ff.pixel_blue,
                    s1_req_ff.pixel_green, s1_req_ff.pixel_red} : held;

   assign m_red   = merged[7:0];
   assign m_green = merged[15:8];
   assign m_blue  = merged[23:16];
   assign m_alpha = merged[31:24];

   assign is_trans = (m_alpha < ALPHA_OPAQUE_MIN);
   assign is_black = !is_trans && (m_red < BLACK_LEVEL_MAX)
                     && (m_green < BLACK_LEVEL_MAX) && (m_blue < BLACK_LEVEL_MAX);

   assign black_next = black_ff + COUNT_W'(s1_req_ff.last_image && is_black);
   assign trans_next = trans_ff + COUNT_W'(s1_req_ff.last_image && is_trans);

   assign black_x4  = 25'({black_next, 2'b00});
   assign trans_x20 = 25'({trans_next, 4'b0000}) + 25'({trans_next, 2'b00});
   assign n_x1      = 25'(n_eff);
   assign n_x3      = 25'({n_eff, 1'b0}) + n_x1;
   assign reject    = s1_end_ff && filter_enable_ff
                      && ((black_x4 > n_x1) || (trans_x20 > n_x3));

   always_comb begin
      black_in = black_ff;
      trans_in = trans_ff;
      if (s1_valid_ff) begin
         if (s1_end_ff) begin
            black_in = '0;
            trans_in = '0;
         end else begin
            black_in = black_next;
            trans_in = trans_next;
         end
      end
   end

   assign push                = s1_valid_ff && s1_req_ff.last_image;
   assign push_data.out_red   = m_red;
   assign push_data.out_green = m_green;
   assign push_data.out_blue  = m_blue;
   assign push_data.out_alpha = m_alpha;
   assign push_data.frame_end = s1_end_ff;
   assign push_data.reject    = reject;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         black_ff    <= '0;
         trans_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         black_ff    <= black_in;
         trans_ff    <= trans_in;
         s1_valid_ff <= accept;
         if (accept) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff   <= req_data;
         s1_addr_ff  <= pos_ff;
         s1_end_ff   <= at_end;
         fwd_ff      <= s1_valid_ff && (s1_addr_ff == pos_ff);
         fwd_data_ff <= merged;
      end
   end

   mitm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .count     (fifo_count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/mitm_rsp_fifo.sv
// Three-entry result queue with occupancy count for input flow control.
module mitm_rsp_fifo import mitm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_type       push_data,
   output logic [1:0]    count,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   rsp_type    entry_ff [RSP_DEPTH];
   logic [1:0] head_ff, head_in;
   logic [1:0] tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[head_ff];
   assign count     = count_ff;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == 2'(RSP_DEPTH - 1)) ? 2'd0 : head_ff + 2'd1;
      end
      if (push) begin
         tail_in = (tail_ff == 2'(RSP_DEPTH - 1)) ? 2'd0 : tail_ff + 2'd1;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule
